// ----- rtl/qnsr_pkg.sv -----
package qnsr_pkg;

    localparam int NEWTON_STEPS   = 4;
    localparam int DIV_BITS       = 30;
    localparam int GUESS_W        = 17;
    localparam int ROOT_W         = 15;
    localparam int SAMPLE_W       = 16;
    localparam int BIT_SEL_W      = 5;
    localparam int CELLS_PER_STEP = DIV_BITS + 1;
    localparam int N_CELLS        = NEWTON_STEPS * CELLS_PER_STEP;

    localparam logic [ROOT_W-1:0] Q15_ONE = 15'h7FFF;

    typedef struct packed {
        logic                vld;
        logic                spec;
        logic [ROOT_W-1:0]   sres;
        logic [DIV_BITS-1:0] scaled;
        logic [GUESS_W-1:0]  guess;
        logic [GUESS_W-1:0]  rem;
        logic [DIV_BITS-1:0] quo;
    } t_word;

endpackage

// ----- rtl/q15_newton_square_root_top.sv -----
// The row holds 4 Newton steps of 31 cells: 30 divider cells and one step cell.
// Throughput: one word per cycle while the row is not stalled; each cell resolves
// one quotient bit or one guess update and registers the word it passes on.
// Stall holds the whole row; the input stalls only while a result waits.
// Reset (i_rst_n low, synchronous) empties every cell.
module q15_newton_square_root_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [qnsr_pkg::SAMPLE_W-1:0] i_sample,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [qnsr_pkg::ROOT_W-1:0]        o_root
);
    import qnsr_pkg::*;

    t_word              w [N_CELLS+1];
    t_word              w_in;
    logic               en;
    logic [GUESS_W-1:0] seed;

    assign o_stall = w[N_CELLS].vld && i_stall;
    assign en      = !o_stall;

    always_comb begin
        seed          = {2'b00, i_sample[SAMPLE_W-1:1]};
        w_in          = '0;
        w_in.vld      = i_valid;
        w_in.spec     = i_sample[SAMPLE_W-1] || (i_sample == '0)
                      || (i_sample[ROOT_W-1:0] == Q15_ONE);
        w_in.sres     = (!i_sample[SAMPLE_W-1] && i_sample[ROOT_W-1:0] == Q15_ONE)
                      ? Q15_ONE : '0;
        w_in.scaled   = {i_sample[ROOT_W-1:0], {ROOT_W{1'b0}}};
        w_in.guess    = (seed == '0) ? GUESS_W'(1) : seed;
    end

    assign w[0] = w_in;

    for (genvar s = 0; s < NEWTON_STEPS; s++) begin : g_step
        for (genvar b = 0; b < DIV_BITS; b++) begin : g_bit
            qnsr_div_cell u_div (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_bit   (BIT_SEL_W'(DIV_BITS - 1 - b)),
                .i_word  (w[s*CELLS_PER_STEP + b]),
                .o_word  (w[s*CELLS_PER_STEP + b + 1])
            );
        end
        qnsr_step_cell u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_word  (w[s*CELLS_PER_STEP + DIV_BITS]),
            .o_word  (w[(s+1)*CELLS_PER_STEP])
        );
    end

    assign o_valid = w[N_CELLS].vld;
    assign o_root  = w[N_CELLS].spec ? w[N_CELLS].sres : w[N_CELLS].guess[ROOT_W-1:0];

endmodule

// ----- rtl/qnsr_div_cell.sv -----
module qnsr_div_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic [qnsr_pkg::BIT_SEL_W-1:0]  i_bit,
    input  qnsr_pkg::t_word                 i_word,
    output qnsr_pkg::t_word                 o_word
);
    import qnsr_pkg::*;

    t_word              r_word;
    t_word              n_word;
    logic [GUESS_W:0]   trial;
    logic [GUESS_W:0]   diff;
    logic               ge;

    always_comb begin
        trial  = {i_word.rem, i_word.scaled[i_bit]};
        ge     = trial >= {1'b0, i_word.guess};
        diff   = trial - {1'b0, i_word.guess};
        n_word = i_word;
        n_word.rem = ge ? diff[GUESS_W-1:0] : trial[GUESS_W-1:0];
        n_word.quo = {i_word.quo[DIV_BITS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
        end else if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

// ----- rtl/qnsr_step_cell.sv -----
module qnsr_step_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  qnsr_pkg::t_word i_word,
    output qnsr_pkg::t_word o_word
);
    import qnsr_pkg::*;

    t_word              r_word;
    t_word              n_word;
    logic [DIV_BITS:0]  sum;

    always_comb begin
        sum          = {{(DIV_BITS+1-GUESS_W){1'b0}}, i_word.guess}
                     + {1'b0, i_word.quo};
        n_word       = i_word;
        n_word.guess = sum[GUESS_W:1];
        n_word.rem   = '0;
        n_word.quo   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
        end else if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

// ----- rtl/qnsr_checker.sv -----
module qnsr_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_stall,
    input logic [qnsr_pkg::SAMPLE_W-1:0]      i_sample,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic [qnsr_pkg::ROOT_W-1:0]        o_root
);
    import qnsr_pkg::*;

    a_stall_needs_result: assert property (@(posedge i_clk)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a waiting result");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_root)))
        else $error("stalled result changed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=> (i_valid && $stable(i_sample)))
        else $error("stalled input changed");

endmodule

bind q15_newton_square_root_top qnsr_checker u_qnsr_checker (.*);
